### rtl/assert_macros.svh
// Assertion macros used by the monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define HOM_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that a consequent holds in the same cycle as its antecedent.
`define HOM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that a consequent holds in the cycle after its antecedent.
`define HOM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HOM_ASSERT(label, clk, rst, cond, msg)
`define HOM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define HOM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/hom_pkg.sv
// Types and constants shared by the bridge overcurrent monitor.
package hom_pkg;

  localparam int CUR_W      = 16;
  localparam int RETRY_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Bridge state codes
  typedef enum logic [1:0] {
    MODE_OFF         = 2'd0,
    MODE_ON          = 2'd1,
    MODE_OVERCURRENT = 2'd2,
    MODE_SHUTDOWN    = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OC_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SD_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_TRACK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THERMAL_ON  = 3'd5;

  // Configuration reset values
  localparam logic [CUR_W-1:0]   OC_LIMIT_RST    = 16'd250;
  localparam logic [CUR_W-1:0]   SD_LIMIT_RST    = 16'd500;
  localparam logic [CUR_W-1:0]   ACK_LIMIT_RST   = 16'd60;
  localparam logic               PROG_TRACK_RST  = 1'b0;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd3;
  localparam logic               THERMAL_ON_RST  = 1'b1;

  localparam logic [RETRY_W-1:0] TRIP_MAX = '1;

  typedef struct packed {
    logic [CUR_W-1:0]   oc_limit;
    logic [CUR_W-1:0]   sd_limit;
    logic [CUR_W-1:0]   ack_limit;
    logic               prog_track;
    logic [RETRY_W-1:0] retry_limit;
    logic               thermal_on;
  } cfg_t;

  typedef struct packed {
    logic [CUR_W-1:0] current_ma;
    logic             bridge_enabled;
    logic             prog_enable;
    logic             thermal_pin;
  } req_t;

  typedef struct packed {
    logic       drive_off;
    logic [1:0] bridge_state;
    logic       service_short;
    logic       service_ack;
    logic       shutdown_report;
    logic       short_report;
    logic       thermal_report;
    logic       thermal_flag;
  } res_t;

endpackage

### rtl/hom_cfg.sv
// Configuration register file of the bridge overcurrent monitor.
module hom_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hom_pkg::CFG_DATA_W-1:0] cfg_data,
  output hom_pkg::cfg_t                 cfg
);
  import hom_pkg::*;

  // Decode the write index and load the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.oc_limit    <= OC_LIMIT_RST;
      cfg.sd_limit    <= SD_LIMIT_RST;
      cfg.ack_limit   <= ACK_LIMIT_RST;
      cfg.prog_track  <= PROG_TRACK_RST;
      cfg.retry_limit <= RETRY_LIMIT_RST;
      cfg.thermal_on  <= THERMAL_ON_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OC_LIMIT:    cfg.oc_limit    <= cfg_data[CUR_W-1:0];
        CFG_SD_LIMIT:    cfg.sd_limit    <= cfg_data[CUR_W-1:0];
        CFG_ACK_LIMIT:   cfg.ack_limit   <= cfg_data[CUR_W-1:0];
        CFG_PROG_TRACK:  cfg.prog_track  <= cfg_data[0];
        CFG_RETRY_LIMIT: cfg.retry_limit <= cfg_data[RETRY_W-1:0];
        CFG_THERMAL_ON:  cfg.thermal_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/hom_eval.sv
// Per-tick evaluation: limit compares, retry counter, bridge state and thermal edge.
`include "assert_macros.svh"
module hom_eval (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  hom_pkg::req_t req,
  input  hom_pkg::cfg_t cfg,
  output hom_pkg::res_t res
);
  import hom_pkg::*;

  mode_t              mode;
  mode_t              mode_next;
  logic [RETRY_W-1:0] trip_count;
  logic [RETRY_W-1:0] trip_count_next;
  logic               thermal;
  logic               thermal_next;
  logic               ge_sd;
  logic               ge_oc;
  logic               ge_ack;
  logic               svc_on;
  logic               trip;

  assign ge_sd  = req.current_ma >= cfg.sd_limit;
  assign ge_oc  = req.current_ma >= cfg.oc_limit;
  assign ge_ack = req.current_ma >= cfg.ack_limit;
  assign svc_on = cfg.prog_track & req.prog_enable;
  assign trip   = trip_count >= cfg.retry_limit;

  // Work out next state and this tick's result
  always_comb begin
    mode_next       = mode;
    trip_count_next = trip_count;
    thermal_next    = thermal;
    res             = '0;

    res.service_short = svc_on & ge_oc;
    res.service_ack   = svc_on & ~ge_oc & ge_ack;

    // Shutdown wins over the overcurrent test whatever the limit order
    if (ge_sd) begin
      res.drive_off = 1'b1;
      mode_next     = MODE_SHUTDOWN;
    end else if (ge_oc) begin
      if (trip_count != TRIP_MAX) begin
        trip_count_next = RETRY_W'(trip_count + 1'b1);
      end
      if (trip) begin
        res.drive_off = 1'b1;
        mode_next     = MODE_OVERCURRENT;
      end
    end else if (req.bridge_enabled) begin
      trip_count_next = '0;
      mode_next       = MODE_ON;
    end else begin
      mode_next = MODE_OFF;
    end

    // Report state changes, shutdown taking precedence
    if (mode_next != mode) begin
      if (mode == MODE_SHUTDOWN || mode_next == MODE_SHUTDOWN) begin
        res.shutdown_report = 1'b1;
      end else if (mode == MODE_OVERCURRENT || mode_next == MODE_OVERCURRENT) begin
        res.short_report = 1'b1;
      end
    end

    // Track the thermal pin only while the monitor is on
    if (cfg.thermal_on) begin
      res.thermal_report = req.thermal_pin ^ thermal;
      thermal_next       = req.thermal_pin;
    end

    res.bridge_state = mode_next;
    res.thermal_flag = thermal_next;
  end

  // Advance the state once per request moved to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_OFF;
      trip_count <= '0;
      thermal    <= 1'b0;
    end else if (adv) begin
      mode       <= mode_next;
      trip_count <= trip_count_next;
      thermal    <= thermal_next;
    end
  end

  `HOM_ASSERT_IMPLY(a_drive_off_mode, clk, rst, adv && res.drive_off, mode_next == MODE_OVERCURRENT || mode_next == MODE_SHUTDOWN, "drive off without a fault state")
  `HOM_ASSERT_IMPLY(a_svc_needs_prog, clk, rst, res.service_short || res.service_ack, cfg.prog_track && req.prog_enable && !(res.service_short && res.service_ack), "service report outside programming mode")
  `HOM_ASSERT_NEXT(a_hold_state, clk, rst, !adv, $stable(mode) && $stable(trip_count) && $stable(thermal), "state moved without a request")
  `HOM_ASSERT(a_one_report, clk, rst, !(res.shutdown_report && res.short_report), "both state reports raised")

endmodule

### rtl/hbridge_overcurrent_monitor_top.sv
// Top level of the bridge overcurrent monitor: request and result registers.
//
//  channel  | handshake            | payload
//  request  | req_valid, req_stall | current_ma, bridge_enabled, prog_enable, thermal_pin
//  result   | res_valid, res_stall | drive_off, bridge_state, service_*, *_report, thermal_flag
//  config   | cfg_we               | cfg_index, cfg_data
//
// One request per cycle is taken while req_stall is low; a request passes through the request
// register, then the compare and counter logic, into the result register.
// Synchronous reset clears the bridge state, retry counter and thermal flag and reloads the config.
// A stalled result holds; the request register then fills and req_stall rises.
module hbridge_overcurrent_monitor_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [hom_pkg::CUR_W-1:0]      current_ma,
  input  logic                           bridge_enabled,
  input  logic                           prog_enable,
  input  logic                           thermal_pin,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           drive_off,
  output logic [1:0]                     bridge_state,
  output logic                           service_short,
  output logic                           service_ack,
  output logic                           shutdown_report,
  output logic                           short_report,
  output logic                           thermal_report,
  output logic                           thermal_flag,
  input  logic                           cfg_we,
  input  logic [hom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hom_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hom_pkg::*;

  cfg_t cfg;
  req_t req_q;
  logic req_full;
  res_t res;
  res_t res_q;
  logic adv;

  hom_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hom_eval u_eval (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .req (req_q),
    .cfg (cfg),
    .res (res)
  );

  // Move the held request on whenever the result register can take it
  assign adv       = req_full & (~res_valid | ~res_stall);
  assign req_stall = req_full & ~adv;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      req_full <= 1'b1;
    end else if (adv) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= '{current_ma:     current_ma,
                 bridge_enabled: bridge_enabled,
                 prog_enable:    prog_enable,
                 thermal_pin:    thermal_pin};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign drive_off       = res_q.drive_off;
  assign bridge_state    = res_q.bridge_state;
  assign service_short   = res_q.service_short;
  assign service_ack     = res_q.service_ack;
  assign shutdown_report = res_q.shutdown_report;
  assign short_report    = res_q.short_report;
  assign thermal_report  = res_q.thermal_report;
  assign thermal_flag    = res_q.thermal_flag;

endmodule

### tb/hom_tick_checker.sv
// Checker for the bridge overcurrent monitor: predicts each status result and compares it.
`timescale 1ns / 100ps

module hom_tick_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_stall,
  input  logic [hom_pkg::CUR_W-1:0]      current_ma,
  input  logic                           bridge_enabled,
  input  logic                           prog_enable,
  input  logic                           thermal_pin,
  input  logic                           res_valid,
  input  logic                           res_stall,
  input  logic                           drive_off,
  input  logic [1:0]                     bridge_state,
  input  logic                           service_short,
  input  logic                           service_ack,
  input  logic                           shutdown_report,
  input  logic                           short_report,
  input  logic                           thermal_report,
  input  logic                           thermal_flag,
  input  logic                           cfg_we,
  input  logic [hom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hom_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  import hom_pkg::*;

  // Local copy of the programmed limits and of the monitor state
  cfg_t               limits;
  mode_t              bridge_mode;
  logic [RETRY_W-1:0] retry_count;
  logic               thermal_seen;

  res_t expected_status_q[$];
  int   mismatch_count = 0;

  assign mismatches = mismatch_count;

  // Advance the local monitor by one poll tick and return the status it reports
  function automatic res_t predict_tick(req_t r);
    res_t  o;
    mode_t prev;
    logic  trip;
    o    = '0;
    prev = bridge_mode;
    trip = 1'b0;
    // Service-mode notifications on the programming track
    if (limits.prog_track && r.prog_enable) begin
      if (r.current_ma >= limits.oc_limit) o.service_short = 1'b1;
      else if (r.current_ma >= limits.ack_limit) o.service_ack = 1'b1;
    end
    // Shutdown test first, then the overcurrent retry, then follow the enable pin
    if (r.current_ma >= limits.sd_limit) begin
      o.drive_off = 1'b1;
      bridge_mode = MODE_SHUTDOWN;
    end else if (r.current_ma >= limits.oc_limit) begin
      trip = (retry_count >= limits.retry_limit);
      if (retry_count != TRIP_MAX) retry_count = retry_count + 1'b1;
      if (trip) begin
        o.drive_off = 1'b1;
        bridge_mode = MODE_OVERCURRENT;
      end
    end else if (r.bridge_enabled) begin
      retry_count = '0;
      bridge_mode = MODE_ON;
    end else begin
      bridge_mode = MODE_OFF;
    end
    // State change reports: shutdown takes priority over overcurrent
    if (prev != bridge_mode) begin
      if (prev == MODE_SHUTDOWN || bridge_mode == MODE_SHUTDOWN) o.shutdown_report = 1'b1;
      else if (prev == MODE_OVERCURRENT || bridge_mode == MODE_OVERCURRENT)
        o.short_report = 1'b1;
    end
    // Thermal flag edge tracking, held while the monitor is off
    if (limits.thermal_on) begin
      o.thermal_report = (r.thermal_pin != thermal_seen);
      thermal_seen     = r.thermal_pin;
    end
    o.bridge_state = bridge_mode;
    o.thermal_flag = thermal_seen;
    return o;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    req_t r;
    res_t got;
    res_t want;
    r   = '{current_ma, bridge_enabled, prog_enable, thermal_pin};
    got = '{drive_off, bridge_state, service_short, service_ack,
            shutdown_report, short_report, thermal_report, thermal_flag};
    if (rst) begin
      limits       = '{OC_LIMIT_RST, SD_LIMIT_RST, ACK_LIMIT_RST, PROG_TRACK_RST,
                       RETRY_LIMIT_RST, THERMAL_ON_RST};
      bridge_mode  = MODE_OFF;
      retry_count  = '0;
      thermal_seen = 1'b0;
      expected_status_q.delete();
    end else begin
      // Track register writes, dropping unused high bits
      if (cfg_we) begin
        case (cfg_index)
          CFG_OC_LIMIT:    limits.oc_limit    = cfg_data[CUR_W-1:0];
          CFG_SD_LIMIT:    limits.sd_limit    = cfg_data[CUR_W-1:0];
          CFG_ACK_LIMIT:   limits.ack_limit   = cfg_data[CUR_W-1:0];
          CFG_PROG_TRACK:  limits.prog_track  = cfg_data[0];
          CFG_RETRY_LIMIT: limits.retry_limit = cfg_data[RETRY_W-1:0];
          CFG_THERMAL_ON:  limits.thermal_on  = cfg_data[0];
          default: ;
        endcase
      end
      // Compare each accepted result against the oldest prediction
      if (res_valid && !res_stall) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, got);
          mismatch_count++;
        end else begin
          want = expected_status_q.pop_front();
          compare_field("drive_off", want.drive_off, got.drive_off);
          compare_field("bridge_state", want.bridge_state, got.bridge_state);
          compare_field("service_short", want.service_short, got.service_short);
          compare_field("service_ack", want.service_ack, got.service_ack);
          compare_field("shutdown_report", want.shutdown_report, got.shutdown_report);
          compare_field("short_report", want.short_report, got.short_report);
          compare_field("thermal_report", want.thermal_report, got.thermal_report);
          compare_field("thermal_flag", want.thermal_flag, got.thermal_flag);
        end
      end
      // Predict the result of each accepted request and queue it at the tail
      if (req_valid && !req_stall)
        expected_status_q.insert(expected_status_q.size(), predict_tick(r));
    end
    outstanding <= expected_status_q.size();
  end

endmodule

### tb/tb.sv
// Testbench top for the bridge overcurrent monitor: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
  import hom_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 12;
  localparam int PHASE_TICKS    = 120;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [CUR_W-1:0]      current_ma = '0;
  logic                  bridge_enabled = 1'b0;
  logic                  prog_enable = 1'b0;
  logic                  thermal_pin = 1'b0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic                  drive_off;
  logic [1:0]            bridge_state;
  logic                  service_short;
  logic                  service_ack;
  logic                  shutdown_report;
  logic                  short_report;
  logic                  thermal_report;
  logic                  thermal_flag;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;

  cfg_t knobs;
  cfg_t next_knobs;
  bit   steady = 1'b0;
  logic pin_level = 1'b0;
  int   idle_cycles = 0;
  int   phase;
  int   count;
  int   burst;

  always #10 clk = ~clk;

  hbridge_overcurrent_monitor_top u_dut (.*);
  hom_tick_checker u_checker (.*);

  // Result side backpressure, off during steady stretches
  always @(posedge clk) res_stall <= !steady && ($urandom_range(99) < 32);

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Issue one poll tick request and hold it until accepted
  task automatic tick(input logic [CUR_W-1:0] cur, input logic en, input logic pe,
                      input logic tp);
    if (!steady && $urandom_range(99) < 32) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid      <= 1'b1;
    current_ma     <= cur;
    bridge_enabled <= en;
    prog_enable    <= pe;
    thermal_pin    <= tp;
    do @(posedge clk); while (req_stall);
  endtask

  // Stop requests and wait until every predicted result has arrived
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // Reprogram every register while idle; narrow registers carry junk in the high bits
  task automatic set_knobs(input cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    drain();
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_OC_LIMIT, c.oc_limit);
    write_reg(CFG_SD_LIMIT, c.sd_limit);
    write_reg(CFG_ACK_LIMIT, c.ack_limit);
    write_reg(CFG_PROG_TRACK, {junk[15:1], c.prog_track});
    write_reg(CFG_RETRY_LIMIT, {junk[15:8], c.retry_limit});
    write_reg(CFG_THERMAL_ON, {~junk[15:1], c.thermal_on});
    cfg_we <= 1'b0;
    @(posedge clk);
    knobs = c;
  endtask

  function automatic logic [CUR_W-1:0] near(input logic [CUR_W-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[CUR_W-1:0];
  endfunction

  // Current between the overcurrent and shutdown limits, where retries count
  function automatic logic [CUR_W-1:0] in_band();
    if (knobs.oc_limit < knobs.sd_limit)
      return CUR_W'($urandom_range(knobs.oc_limit, knobs.sd_limit - 1));
    return knobs.oc_limit;
  endfunction

  function automatic logic [CUR_W-1:0] pick_current();
    case ($urandom_range(9))
      0:       return CUR_W'($urandom);
      1:       return '0;
      2:       return '1;
      3, 4:    return near(knobs.oc_limit);
      5, 6:    return near(knobs.sd_limit);
      7:       return near(knobs.ack_limit);
      default: return in_band();
    endcase
  endfunction

  function automatic logic [CUR_W-1:0] rand_limit();
    if ($urandom_range(3) == 0) return CUR_W'($urandom);
    return CUR_W'($urandom_range(0, 1000));
  endfunction

  // Thermal pin mostly steady with occasional edges
  function automatic logic next_pin();
    if ($urandom_range(4) == 0) pin_level = ~pin_level;
    return pin_level;
  endfunction

  initial begin
    knobs = '{OC_LIMIT_RST, SD_LIMIT_RST, ACK_LIMIT_RST, PROG_TRACK_RST,
              RETRY_LIMIT_RST, THERMAL_ON_RST};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset limits, walk through on, shutdown, retries and overcurrent
    tick(16'd0, 1'b1, 1'b0, 1'b0);
    tick(16'hFFFF, 1'b1, 1'b0, 1'b1);
    tick(16'd0, 1'b0, 1'b0, 1'b1);
    repeat (5) tick(16'd250, 1'b1, 1'b0, 1'b1);
    tick(16'd249, 1'b1, 1'b0, 1'b0);
    tick(16'd499, 1'b1, 1'b0, 1'b0);
    tick(16'd500, 1'b1, 1'b0, 1'b0);
    // Retry while in shutdown keeps the state
    tick(16'd499, 1'b1, 1'b0, 1'b0);
    tick(16'd0, 1'b1, 1'b0, 1'b0);

    // Directed: programming track service mode, immediate trip, thermal monitor off
    next_knobs = '{16'd250, 16'd500, 16'd60, 1'b1, 8'd0, 1'b0};
    set_knobs(next_knobs);
    tick(16'd59, 1'b1, 1'b1, 1'b0);
    tick(16'd60, 1'b1, 1'b1, 1'b0);
    tick(16'd249, 1'b1, 1'b1, 1'b0);
    tick(16'd250, 1'b1, 1'b1, 1'b0);
    tick(16'd250, 1'b1, 1'b0, 1'b1);
    tick(16'd0, 1'b0, 1'b1, 1'b0);

    // Directed: shutdown limit below the overcurrent limit
    next_knobs = '{16'd1000, 16'd100, 16'd60, 1'b1, 8'd255, 1'b1};
    set_knobs(next_knobs);
    tick(16'd100, 1'b1, 1'b0, 1'b0);
    tick(16'd1000, 1'b1, 1'b0, 1'b0);
    tick(16'd99, 1'b1, 1'b0, 1'b1);
    tick(16'hFFFF, 1'b1, 1'b1, 1'b1);
    tick(16'd0, 1'b0, 1'b0, 1'b1);

    // Random phases: all-max and all-zero settings first, then random settings
    for (phase = 0; phase < PHASES; phase++) begin
      steady = (phase == 4);
      if (phase == 0) next_knobs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'd255, 1'b1};
      else if (phase == 1) next_knobs = '0;
      else begin
        next_knobs.oc_limit   = rand_limit();
        next_knobs.sd_limit   = rand_limit();
        next_knobs.ack_limit  = rand_limit();
        next_knobs.prog_track = 1'($urandom_range(1));
        case ($urandom_range(4))
          0:       next_knobs.retry_limit = 8'd0;
          1:       next_knobs.retry_limit = 8'd255;
          default: next_knobs.retry_limit = RETRY_W'($urandom_range(0, 6));
        endcase
        next_knobs.thermal_on = ($urandom_range(3) != 0);
      end
      set_knobs(next_knobs);
      count = 0;
      while (count < PHASE_TICKS) begin
        if ($urandom_range(3) == 0) begin
          // Overcurrent run of random length, which can use up the retries
          burst = $urandom_range(1, (knobs.retry_limit > 8) ? 12 : knobs.retry_limit + 3);
          repeat (burst) begin
            tick(in_band(), $urandom_range(7) != 0, 1'($urandom_range(1)), next_pin());
            count++;
          end
        end else begin
          tick(pick_current(), $urandom_range(3) != 0, 1'($urandom_range(1)), next_pin());
          count++;
        end
      end
    end

    // Long overcurrent run: retry counter reaches saturation and trips
    steady     = 1'b1;
    next_knobs = '{16'd100, 16'd60000, 16'd50, 1'b1, 8'd255, 1'b1};
    set_knobs(next_knobs);
    repeat (300) tick(in_band(), 1'b1, 1'($urandom_range(1)), next_pin());
    repeat (10) tick(pick_current(), 1'($urandom_range(1)), 1'($urandom_range(1)), next_pin());
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/hom_pkg.sv
rtl/hom_cfg.sv
rtl/hom_eval.sv
rtl/hbridge_overcurrent_monitor_top.sv
tb/hom_tick_checker.sv
tb/tb.sv
